@@ src/cltcp_pkg.sv @@
// ----------------------------------------------------------------------------
// Console line time command parser: shared package
// Line buffer sizing, character codes, command words, field limits and the
// types passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package cltcp_pkg;

  // Line buffer: one slot is kept free, so a line holds LINE_CAPACITY-1 bytes.
  localparam int unsigned LINE_CAPACITY = 48;
  localparam int unsigned MEM_DEPTH     = LINE_CAPACITY - 1;
  localparam int unsigned LEN_W         = $clog2(LINE_CAPACITY);
  localparam int unsigned ADDR_W        = $clog2(MEM_DEPTH);
  localparam int unsigned IDX_W         = $clog2(LINE_CAPACITY + 2);

  // Command word and time fields.
  localparam int unsigned WORD_MAX   = 11;
  localparam int unsigned WLEN_W     = 4;
  localparam int unsigned NUM_WORDS  = 4;
  localparam int unsigned NUM_FIELDS = 6;
  localparam int unsigned FLD_W      = 3;
  localparam int unsigned NDIG_W     = 3;
  localparam int unsigned ACC_W      = 14;
  localparam int unsigned VAL_W      = 12;

  // Character codes.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_QUERY   = 8'h3F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // Command words.
  localparam logic [1:0] WD_QUERY   = 2'd0;
  localparam logic [1:0] WD_HELP    = 2'd1;
  localparam logic [1:0] WD_TIME    = 2'd2;
  localparam logic [1:0] WD_SETTIME = 2'd3;

  localparam logic [8*4-1:0] STR_HELP    = "HELP";
  localparam logic [8*4-1:0] STR_TIME    = "TIME";
  localparam logic [8*7-1:0] STR_SETTIME = "SETTIME";

  localparam logic [WLEN_W-1:0] LEN_QUERY   = WLEN_W'(1);
  localparam logic [WLEN_W-1:0] LEN_HELP    = WLEN_W'(4);
  localparam logic [WLEN_W-1:0] LEN_TIME    = WLEN_W'(4);
  localparam logic [WLEN_W-1:0] LEN_SETTIME = WLEN_W'(7);

  typedef enum logic [1:0] {
    EV_ECHO  = 2'd0,
    EV_ERASE = 2'd1,
    EV_LINE  = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    CMD_HELP      = 3'd0,
    CMD_SHOW_TIME = 3'd1,
    CMD_SET_TIME  = 3'd2,
    CMD_USAGE     = 3'd3,
    CMD_UNKNOWN   = 3'd4
  } command_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_WORD,
    ST_SKIP,
    ST_FIELD,
    ST_SET_OK
  } ctl_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_STORE,
    OP_ERASE,
    OP_START,
    OP_WORD,
    OP_SCAN,
    OP_FIELD,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e   op;
    command_e code;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic     in_eol;
    logic     in_erase;
    logic     len_empty;
    logic     len_full;
    logic     ch_zero;
    logic     ch_space;
    logic     word_full;
    command_e word_cmd;
    logic     dig_take;
    logic     fld_good;
    logic     fld_last;
    logic     out_busy;
  } dp_status_t;

  typedef struct packed {
    event_e      event_kind;
    logic [7:0]  echo_char;
    command_e    command_code;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [11:0] year_value;
  } result_t;

  function automatic logic [WLEN_W-1:0] word_len(input logic [1:0] w);
    logic [WLEN_W-1:0] n;
    case (w)
      WD_QUERY: n = LEN_QUERY;
      WD_HELP:  n = LEN_HELP;
      WD_TIME:  n = LEN_TIME;
      default:  n = LEN_SETTIME;
    endcase
    return n;
  endfunction

  // Character of a command word at a position; help, time and settime give NUL at or past their length.
  function automatic logic [7:0] word_char(input logic [1:0] w,
                                           input logic [WLEN_W-1:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    case (w)
      WD_QUERY: c = CH_QUERY;
      WD_HELP:  if (pos < LEN_HELP) c = STR_HELP[8*(3 - int'(pos)) +: 8];
      WD_TIME:  if (pos < LEN_TIME) c = STR_TIME[8*(3 - int'(pos)) +: 8];
      default:  if (pos < LEN_SETTIME) c = STR_SETTIME[8*(6 - int'(pos)) +: 8];
    endcase
    return c;
  endfunction

  // Time fields in order: hour, minute, second, day, month, year.
  function automatic logic [NDIG_W-1:0] fld_digits(input logic [FLD_W-1:0] k);
    return (k == FLD_W'(NUM_FIELDS - 1)) ? NDIG_W'(4) : NDIG_W'(2);
  endfunction

  function automatic logic [VAL_W-1:0] fld_low(input logic [FLD_W-1:0] k);
    logic [VAL_W-1:0] v;
    case (k) inside
      3'd3, 3'd4: v = VAL_W'(1);
      3'd5:       v = VAL_W'(2000);
      default:    v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [VAL_W-1:0] fld_high(input logic [FLD_W-1:0] k);
    logic [VAL_W-1:0] v;
    case (k)
      3'd0:    v = VAL_W'(23);
      3'd1:    v = VAL_W'(59);
      3'd2:    v = VAL_W'(59);
      3'd3:    v = VAL_W'(31);
      3'd4:    v = VAL_W'(12);
      default: v = VAL_W'(2099);
    endcase
    return v;
  endfunction

  function automatic logic [7:0] fld_sep(input logic [FLD_W-1:0] k);
    logic [7:0] c;
    case (k) inside
      3'd0, 3'd1: c = CH_COLON;
      3'd2:       c = CH_SPACE;
      3'd3, 3'd4: c = CH_SLASH;
      default:    c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

@@ src/cltcp_rx_if.sv @@
// ----------------------------------------------------------------------------
// Console line time command parser: received byte channel
// Valid/ready channel carrying one console byte per request.
// ----------------------------------------------------------------------------
interface cltcp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ src/cltcp_evt_if.sv @@
// ----------------------------------------------------------------------------
// Console line time command parser: event channel
// Valid/ready channel carrying one echo, erase or decoded line event.
// ----------------------------------------------------------------------------
interface cltcp_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  echo_char;
  logic [2:0]  command_code;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [11:0] year_value;

  modport source (output valid, output event_kind, output echo_char, output command_code,
                  output hours, output minutes, output seconds, output day_of_month,
                  output month_number, output year_value, input ready);
  modport sink (input valid, input event_kind, input echo_char, input command_code,
                input hours, input minutes, input seconds, input day_of_month,
                input month_number, input year_value, output ready);
endinterface

@@ src/cltcp_dp.sv @@
// ----------------------------------------------------------------------------
// Console line time command parser: datapath
// Line memory, length counter, streaming word matcher, time field
// accumulator and the output register.
// ----------------------------------------------------------------------------
module cltcp_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           rx_byte_i,
  input  cltcp_pkg::dp_cmd_t   cmd_i,
  output cltcp_pkg::dp_status_t status_o,
  cltcp_evt_if.source          evt_o
);
  import cltcp_pkg::*;

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rdata_q;
  logic [IDX_W-1:0]  cur_q;
  logic [IDX_W-1:0]  rd_ptr_q, rd_ptr_d, rd_addr;
  logic [LEN_W-1:0]  len_q, len_d;

  logic [WLEN_W-1:0]    wlen_q, wlen_d;
  logic [NUM_WORDS-1:0] wok_q, wok_d;

  logic [FLD_W-1:0]  fld_q, fld_d;
  logic [NDIG_W-1:0] ndig_q, ndig_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [VAL_W-1:0]  vals_q [NUM_FIELDS];

  result_t res_q, res_d;
  result_t out_q;
  logic    out_valid_q;

  logic [7:0] ch, ch_up;
  logic       is_digit, advance;
  logic [3:0] digit;
  command_e   word_cmd;

  // Bytes at or past the line length read as zero, which ends the line.
  assign ch       = (cur_q < IDX_W'(len_q)) ? rdata_q : CH_NUL;
  assign ch_up    = (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ? ch - CASE_DELTA : ch;
  assign is_digit = (ch >= CH_DIGIT_0) && (ch <= CH_DIGIT_9);
  assign digit    = 4'(ch - CH_DIGIT_0);

  always_comb begin
    if (wok_q[WD_QUERY] && wlen_q == LEN_QUERY) begin
      word_cmd = CMD_HELP;
    end else if (wok_q[WD_HELP] && wlen_q == LEN_HELP) begin
      word_cmd = CMD_HELP;
    end else if (wok_q[WD_TIME] && wlen_q == LEN_TIME) begin
      word_cmd = CMD_SHOW_TIME;
    end else if (wok_q[WD_SETTIME] && wlen_q == LEN_SETTIME) begin
      word_cmd = CMD_SET_TIME;
    end else begin
      word_cmd = CMD_UNKNOWN;
    end
  end

  always_comb begin
    status_o.in_eol    = (rx_byte_i == CH_CR) || (rx_byte_i == CH_LF);
    status_o.in_erase  = (rx_byte_i == CH_BS) || (rx_byte_i == CH_DEL);
    status_o.len_empty = (len_q == '0);
    status_o.len_full  = (len_q == LEN_W'(LINE_CAPACITY - 1));
    status_o.ch_zero   = (ch == CH_NUL);
    status_o.ch_space  = (ch == CH_SPACE);
    status_o.word_full = (wlen_q == WLEN_W'(WORD_MAX - 1));
    status_o.word_cmd  = word_cmd;
    status_o.dig_take  = is_digit && (ndig_q < fld_digits(fld_q));
    status_o.fld_good  = (ndig_q != '0) && (acc_q >= ACC_W'(fld_low(fld_q)))
                         && (acc_q <= ACC_W'(fld_high(fld_q))) && (ch == fld_sep(fld_q));
    status_o.fld_last  = (fld_q == FLD_W'(NUM_FIELDS - 1));
    status_o.out_busy  = out_valid_q && !evt_o.ready;
  end

  // One line byte is read per cycle while a line is being decoded.
  always_comb begin
    advance  = (cmd_i.op == OP_START) || (cmd_i.op == OP_WORD)
               || (cmd_i.op == OP_SCAN) || (cmd_i.op == OP_FIELD);
    rd_addr  = (cmd_i.op == OP_START) ? '0 : rd_ptr_q;
    rd_ptr_d = advance ? rd_addr + IDX_W'(1) : rd_ptr_q;
  end

  always_comb begin
    len_d  = len_q;
    wlen_d = wlen_q;
    wok_d  = wok_q;
    fld_d  = fld_q;
    ndig_d = ndig_q;
    acc_d  = acc_q;
    res_d  = res_q;
    case (cmd_i.op)
      OP_STORE: begin
        len_d = len_q + LEN_W'(1);
        res_d = '0;
        res_d.event_kind = EV_ECHO;
        res_d.echo_char  = rx_byte_i;
      end
      OP_ERASE: begin
        len_d = len_q - LEN_W'(1);
        res_d = '0;
        res_d.event_kind = EV_ERASE;
      end
      OP_START: begin
        wlen_d = '0;
        wok_d  = '1;
        fld_d  = '0;
        ndig_d = '0;
        acc_d  = '0;
      end
      OP_WORD: begin
        for (int w = 0; w < NUM_WORDS; w++) begin
          wok_d[w] = wok_q[w] && (wlen_q < word_len(2'(w)))
                     && (ch_up == word_char(2'(w), wlen_q));
        end
        wlen_d = wlen_q + WLEN_W'(1);
      end
      OP_FIELD: begin
        if (status_o.dig_take) begin
          acc_d  = ACC_W'({acc_q, 3'b000}) + ACC_W'({acc_q, 1'b0}) + ACC_W'(digit);
          ndig_d = ndig_q + NDIG_W'(1);
        end else begin
          fld_d  = fld_q + FLD_W'(1);
          ndig_d = '0;
          acc_d  = '0;
        end
      end
      OP_FINISH: begin
        len_d = '0;
        res_d = '0;
        res_d.event_kind   = EV_LINE;
        res_d.command_code = cmd_i.code;
        if (cmd_i.code == CMD_SET_TIME) begin
          res_d.hours        = 5'(vals_q[0]);
          res_d.minutes      = 6'(vals_q[1]);
          res_d.seconds      = 6'(vals_q[2]);
          res_d.day_of_month = 5'(vals_q[3]);
          res_d.month_number = 4'(vals_q[4]);
          res_d.year_value   = vals_q[5];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_STORE) begin
      mem[len_q[ADDR_W-1:0]] <= rx_byte_i;
    end
    rdata_q <= mem[rd_addr[ADDR_W-1:0]];
    cur_q   <= rd_addr;
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    wlen_q   <= wlen_d;
    wok_q    <= wok_d;
    fld_q    <= fld_d;
    ndig_q   <= ndig_d;
    acc_q    <= acc_d;
    res_q    <= res_d;
    if (cmd_i.op == OP_FIELD && !status_o.dig_take) begin
      vals_q[fld_q] <= acc_q[VAL_W-1:0];
    end
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (evt_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign evt_o.valid        = out_valid_q;
  assign evt_o.event_kind   = out_q.event_kind;
  assign evt_o.echo_char    = out_q.echo_char;
  assign evt_o.command_code = out_q.command_code;
  assign evt_o.hours        = out_q.hours;
  assign evt_o.minutes      = out_q.minutes;
  assign evt_o.seconds      = out_q.seconds;
  assign evt_o.day_of_month = out_q.day_of_month;
  assign evt_o.month_number = out_q.month_number;
  assign evt_o.year_value   = out_q.year_value;

endmodule

@@ src/cltcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Console line time command parser: controller
// Sequences byte handling, the command word scan and the time field parse,
// and hands finished events to the output register.
// ----------------------------------------------------------------------------
module cltcp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cltcp_pkg::dp_status_t status_i,
  output cltcp_pkg::dp_cmd_t    cmd_o
);
  import cltcp_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: OP_NONE, code: CMD_HELP, emit: 1'b0};
    unique case (state_q) inside
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.in_eol) begin
            if (!status_i.len_empty) begin
              cmd_o.op = OP_START;
              state_d  = ST_WORD;
            end
          end else if (status_i.in_erase) begin
            if (!status_i.len_empty) begin
              cmd_o.op = OP_ERASE;
              state_d  = ST_EMIT;
            end
          end else if (!status_i.len_full) begin
            cmd_o.op = OP_STORE;
            state_d  = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_WORD: begin
        if (status_i.ch_zero || status_i.ch_space) begin
          if (status_i.word_cmd == CMD_SET_TIME && status_i.ch_space) begin
            cmd_o.op = OP_SCAN;
            state_d  = ST_SKIP;
          end else begin
            // A settime word ended by the end of the line has no time to parse.
            cmd_o.op   = OP_FINISH;
            cmd_o.code = (status_i.word_cmd == CMD_SET_TIME) ? CMD_USAGE
                                                             : status_i.word_cmd;
            state_d    = ST_EMIT;
          end
        end else if (status_i.word_full) begin
          cmd_o.op   = OP_FINISH;
          cmd_o.code = CMD_UNKNOWN;
          state_d    = ST_EMIT;
        end else begin
          cmd_o.op = OP_WORD;
        end
      end
      ST_SKIP, ST_FIELD: begin
        if (state_q == ST_SKIP && status_i.ch_space) begin
          cmd_o.op = OP_SCAN;
        end else if (status_i.dig_take) begin
          cmd_o.op = OP_FIELD;
          state_d  = ST_FIELD;
        end else if (status_i.fld_good) begin
          cmd_o.op = OP_FIELD;
          state_d  = status_i.fld_last ? ST_SET_OK : ST_FIELD;
        end else begin
          cmd_o.op   = OP_FINISH;
          cmd_o.code = CMD_USAGE;
          state_d    = ST_EMIT;
        end
      end
      ST_SET_OK: begin
        cmd_o.op   = OP_FINISH;
        cmd_o.code = CMD_SET_TIME;
        state_d    = ST_EMIT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/console_line_time_command_parser.sv @@
// ----------------------------------------------------------------------------
// Console line time command parser
// Line editor for console bytes with a decoder for the help, time and
// settime commands.
//
//   Port    Direction  Carries
//   rx_i    in         rx_byte, one received console byte per request
//   evt_o   out        echo, erase or decoded line event with the parsed time
//
// An ordinary byte or an erase is registered as its event, which moves into
// the output register once the output is not busy. End of line reads the
// line memory one byte per cycle through its single read port. Reset empties
// the line and clears the output valid flag. The input is taken only while
// no request is in work and its event has left for the output register; a
// stalled output holds the next event back.
// ----------------------------------------------------------------------------
module console_line_time_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  cltcp_rx_if.sink    rx_i,
  cltcp_evt_if.source evt_o
);
  import cltcp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign rx_i.ready = in_ready;

  cltcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cltcp_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (rx_i.rx_byte),
    .cmd_i     (cmd),
    .status_o  (status),
    .evt_o     (evt_o)
  );

endmodule
